/* hdl/wasi_pkg.sv */
// Shared types and codes for the window argmax span integrator.
`timescale 1ns / 1ps
`default_nettype none
package wasi_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [2:0] REG_SRC_QL = 3'd0;
  localparam logic [2:0] REG_SRC_TL = 3'd1;
  localparam logic [2:0] REG_DST_QL = 3'd2;
  localparam logic [2:0] REG_DST_TL = 3'd3;
  localparam logic [2:0] REG_WIN_LQ = 3'd4;
  localparam logic [2:0] REG_WIN_HQ = 3'd5;
  localparam logic [2:0] REG_WIN_LT = 3'd6;
  localparam logic [2:0] REG_WIN_HT = 3'd7;

endpackage
`default_nettype wire

/* hdl/wasi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module wasi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hdl/window_argmax_span_integrator.sv */
// Top level: score matrix store, window clip, and sequential argmax scan.
//
// Usage. Commands enter on start/kind/row_index/col_index/score_in and are
// taken at an edge where start is high and busy is low. Kind clear sweeps the
// whole score RAM back to the empty sentinel, one entry per cycle, over all
// 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) entries (4096 at the defaults). Kind
// write stores one score in the accept cycle and leaves busy low. Kind query
// clips the window to the source matrix and reads it row-major through the
// single RAM read port, one cell per cycle, with one shared signed compare
// tracking the running best. The result shows on found/best_row/best_col/
// best_score for one cycle marked by done, after the setup, scan and drain
// states; an empty or out-of-range query goes from setup straight to the
// result. Busy stays high until the done cycle has passed. Query time is
// set by the RAM read port: one cell per cycle.
// The receiver cannot stall; done lasts exactly one cycle.
// Configuration goes through the APB port (register i at byte 4*i); write it
// only while busy is low. Reset starts the same clearing sweep as kind
// clear, so busy stays high after rst falls until the sweep is done.
`timescale 1ns / 1ps
`default_nettype none
module window_argmax_span_integrator #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int SCORE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  kind,
  input  wire logic [5:0]  row_index,
  input  wire logic [5:0]  col_index,
  input  wire logic signed [31:0] score_in,
  output logic             done,
  output logic             found,
  output logic      [5:0]  best_row,
  output logic      [5:0]  best_col,
  output logic signed [31:0] best_score
);
  import wasi_pkg::*;

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 2 ** AW;
  localparam logic signed [10:0] ROW_LAST = 11'(MAX_ROWS - 1);
  localparam logic signed [10:0] COL_LAST = 11'(MAX_COLS - 1);
  localparam logic [SCORE_BITS-1:0] SENTINEL = {1'b1, {(SCORE_BITS-1){1'b0}}};

  // configuration registers
  logic [5:0] src_ql, src_tl, dst_ql, dst_tl;
  logic [8:0] win_lq, win_hq, win_lt, win_ht;

  state_t state, state_next;
  logic [AW-1:0] clr_cnt;
  logic [5:0] q_row, q_col;
  logic [5:0] r1, c0, c1;
  logic [5:0] x, y;
  logic       pend;
  logic [5:0] pend_x, pend_y;
  logic signed [SCORE_BITS-1:0] best;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [SCORE_BITS-1:0] ram_wdata, ram_rdata;

  logic accept;
  assign accept = start && !busy;

  // APB
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[4:2])
      REG_SRC_QL: prdata = {26'b0, src_ql};
      REG_SRC_TL: prdata = {26'b0, src_tl};
      REG_DST_QL: prdata = {26'b0, dst_ql};
      REG_DST_TL: prdata = {26'b0, dst_tl};
      REG_WIN_LQ: prdata = {23'b0, win_lq};
      REG_WIN_HQ: prdata = {23'b0, win_hq};
      REG_WIN_LT: prdata = {23'b0, win_lt};
      REG_WIN_HT: prdata = {23'b0, win_ht};
      default:    prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_ql <= 6'd63;
      src_tl <= 6'd63;
      dst_ql <= 6'd63;
      dst_tl <= 6'd63;
      win_lq <= 9'd0;
      win_hq <= 9'd0;
      win_lt <= 9'd0;
      win_ht <= 9'd0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_SRC_QL: src_ql <= pwdata[5:0];
        REG_SRC_TL: src_tl <= pwdata[5:0];
        REG_DST_QL: dst_ql <= pwdata[5:0];
        REG_DST_TL: dst_tl <= pwdata[5:0];
        REG_WIN_LQ: win_lq <= pwdata[8:0];
        REG_WIN_HQ: win_hq <= pwdata[8:0];
        REG_WIN_LT: win_lt <= pwdata[8:0];
        REG_WIN_HT: win_ht <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // window clip, evaluated in the setup cycle
  logic signed [10:0] rlo, rhi, clo, chi, sql, stl, r0_s, r1_s, c0_s, c1_s;
  logic win_empty;

  always_comb begin
    rlo = $signed({5'b0, q_row}) + $signed({{2{win_lq[8]}}, win_lq});
    rhi = $signed({5'b0, q_row}) + $signed({{2{win_hq[8]}}, win_hq});
    clo = $signed({5'b0, q_col}) + $signed({{2{win_lt[8]}}, win_lt});
    chi = $signed({5'b0, q_col}) + $signed({{2{win_ht[8]}}, win_ht});
    sql = $signed({5'b0, src_ql});
    stl = $signed({5'b0, src_tl});
    if (sql > ROW_LAST) begin
      sql = ROW_LAST;
    end
    if (stl > COL_LAST) begin
      stl = COL_LAST;
    end
    r0_s = (rlo < 0) ? 11'sd0 : rlo;
    c0_s = (clo < 0) ? 11'sd0 : clo;
    r1_s = (rhi > sql) ? sql : rhi;
    c1_s = (chi > stl) ? stl : chi;
    win_empty = (q_row > dst_ql) || (q_col > dst_tl) || (r0_s > r1_s) || (c0_s > c1_s);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && kind == KIND_CLEAR) begin
          state_next = ST_CLEAR;
        end else if (accept && kind == KIND_QUERY) begin
          state_next = ST_SETUP;
        end
      end
      ST_CLEAR: begin
        if (clr_cnt == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_SETUP:  state_next = win_empty ? ST_RESULT : ST_SCAN;
      ST_SCAN: begin
        if (x == r1 && y == c1) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_next = ST_RESULT;
      ST_RESULT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // write-path address and data
  logic [15:0] wr_row16, wr_col16, x16, y16;
  logic        wr_in_range;
  logic signed [63:0] score_ext;
  assign wr_row16    = {10'b0, row_index};
  assign wr_col16    = {10'b0, col_index};
  assign x16         = {10'b0, x};
  assign y16         = {10'b0, y};
  assign wr_in_range = (wr_row16 < 16'(MAX_ROWS)) && (wr_col16 < 16'(MAX_COLS));
  assign score_ext   = 64'(score_in);

  // outputs of the sequencer
  always_comb begin
    busy      = (state != ST_IDLE);
    done      = (state == ST_RESULT);
    ram_we    = 1'b0;
    ram_waddr = {wr_row16[RW-1:0], wr_col16[CW-1:0]};
    ram_wdata = score_ext[SCORE_BITS-1:0];
    ram_raddr = {x16[RW-1:0], y16[CW-1:0]};
    case (state)
      ST_IDLE: begin
        ram_we = accept && (kind == KIND_WRITE) && wr_in_range;
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = SENTINEL;
      end
      default: ;
    endcase
  end

  wasi_ram #(
    .WIDTH(SCORE_BITS),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      pend    <= 1'b0;
      found   <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == ST_SCAN);
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (state == ST_IDLE && accept && kind == KIND_QUERY) begin
        found <= 1'b0;
      end else if (pend && $signed(ram_rdata) > best) begin
        found <= 1'b1;
      end
    end
  end

  // scan walk and running best (shared compare)
  always_ff @(posedge clk) begin
    pend_x <= x;
    pend_y <= y;
    case (state)
      ST_IDLE: begin
        q_row    <= row_index;
        q_col    <= col_index;
        best     <= SENTINEL;
        best_row <= 6'd0;
        best_col <= 6'd0;
      end
      ST_SETUP: begin
        x  <= r0_s[5:0];
        y  <= c0_s[5:0];
        r1 <= r1_s[5:0];
        c0 <= c0_s[5:0];
        c1 <= c1_s[5:0];
      end
      ST_SCAN: begin
        if (y == c1) begin
          y <= c0;
          x <= x + 6'd1;
        end else begin
          y <= y + 6'd1;
        end
      end
      default: ;
    endcase
    if (pend && $signed(ram_rdata) > best) begin
      best     <= $signed(ram_rdata);
      best_row <= pend_x;
      best_col <= pend_y;
    end
  end

  logic signed [63:0] best_ext;
  assign best_ext   = 64'(best);
  assign best_score = best_ext[31:0];

endmodule
`default_nettype wire

/* hdl/wasi_checker.sv */
// Port-level checks for the window argmax span integrator, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
module wasi_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] kind,
  input wire logic       done,
  input wire logic       found,
  input wire logic [5:0] best_row,
  input wire logic [5:0] best_col
);
  import wasi_pkg::*;

  // reset always starts the clearing sweep
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result shown while idle");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result longer than one cycle");

  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (best_row == 6'd0 && best_col == 6'd0))
    else $error("not-found result with nonzero position");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == KIND_QUERY) |=> (busy && !done))
    else $error("query transfer did not hold the block busy");

endmodule

bind window_argmax_span_integrator wasi_checker u_wasi_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .kind    (kind),
  .done    (done),
  .found   (found),
  .best_row(best_row),
  .best_col(best_col)
);
`default_nettype wire

/* bench/tb_window_argmax_span_integrator.sv */
// Self-checking bench for the window argmax span integrator: score writes, clears, queries.
`timescale 1ns / 1ps
module tb_window_argmax_span_integrator;
  import wasi_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic signed [31:0] SCORE_EMPTY = 32'sh8000_0000;
  localparam logic signed [31:0] SCORE_TOP = 32'sh7fff_ffff;
  localparam int TAIL_ITEMS = 150;
  localparam int NUM_PHASES = 14;

  typedef struct {
    logic              found;
    logic [5:0]        row;
    logic [5:0]        col;
    logic signed [31:0] score;
  } best_cell_t;

  typedef struct {
    logic [1:0]         kind;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] score;
    bit                 typed;
    best_cell_t         want;
  } command_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic start, busy, done, found;
  logic [1:0] kind;
  logic [5:0] row_index, col_index, best_row, best_col;
  logic signed [31:0] score_in, best_score;

  // bench copy of the block's state and registers
  logic signed [31:0] score_mem [64][64];
  logic [5:0] src_ql, src_tl, dst_ql, dst_tl;
  logic signed [8:0] win_lq, win_hq, win_lt, win_ht;

  best_cell_t pending_best[$];
  command_t sweep_table[$];
  int err_count = 0;
  int n_sent = 0, n_writes = 0, n_queries = 0, n_hits = 0, n_clears = 0, n_settings = 0;
  int planned = 0;

  always #6 clk = ~clk;

  window_argmax_span_integrator u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .kind(kind), .row_index(row_index),
    .col_index(col_index), .score_in(score_in),
    .done(done), .found(found), .best_row(best_row), .best_col(best_col),
    .best_score(best_score)
  );

  function automatic void wipe_scores();
    foreach (score_mem[r, c]) score_mem[r][c] = SCORE_EMPTY;
  endfunction

  // first strictly greatest cell of the clipped window, row-major
  function automatic best_cell_t predict_best(input logic [5:0] qi, input logic [5:0] qj);
    best_cell_t b;
    int lq, hq, lt, ht, r0, r1, c0, c1, x, y;
    b.found = 1'b0;
    b.row = '0;
    b.col = '0;
    b.score = SCORE_EMPTY;
    lq = int'(win_lq);
    hq = int'(win_hq);
    lt = int'(win_lt);
    ht = int'(win_ht);
    if (qi <= dst_ql && qj <= dst_tl) begin
      r0 = int'(qi) + lq;
      if (r0 < 0) r0 = 0;
      r1 = int'(qi) + hq;
      if (r1 > int'(src_ql)) r1 = int'(src_ql);
      c0 = int'(qj) + lt;
      if (c0 < 0) c0 = 0;
      c1 = int'(qj) + ht;
      if (c1 > int'(src_tl)) c1 = int'(src_tl);
      for (x = r0; x <= r1; x++) begin
        for (y = c0; y <= c1; y++) begin
          if (score_mem[x][y] > b.score) begin
            b.score = score_mem[x][y];
            b.row = 6'(x);
            b.col = 6'(y);
            b.found = 1'b1;
          end
        end
      end
    end
    return b;
  endfunction

  function automatic void apply_command(input command_t c);
    case (c.kind)
      KIND_CLEAR: begin
        wipe_scores();
        n_clears++;
      end
      KIND_WRITE: begin
        score_mem[c.row][c.col] = c.score;
        n_writes++;
      end
      KIND_QUERY: begin
        pending_best.push_back(c.typed ? c.want : predict_best(c.row, c.col));
        n_queries++;
      end
      default: ;
    endcase
    n_sent++;
  endfunction

  function automatic void add_row(input logic [1:0] k, input logic [5:0] r, input logic [5:0] c,
                                  input logic signed [31:0] s, input bit typed, input logic f,
                                  input logic [5:0] br, input logic [5:0] bc,
                                  input logic signed [31:0] bs);
    command_t e;
    e.kind = k;
    e.row = r;
    e.col = c;
    e.score = s;
    e.typed = typed;
    e.want.found = f;
    e.want.row = br;
    e.want.col = bc;
    e.want.score = bs;
    sweep_table.push_back(e);
  endfunction

  function automatic int clip63(input int v);
    return (v < 0) ? 0 : ((v > 63) ? 63 : v);
  endfunction

  function automatic logic signed [31:0] pick_score();
    int m;
    m = $urandom_range(0, 99);
    if (m < 25) return 32'($urandom_range(0, 3));  // small values make ties
    if (m < 35) return SCORE_EMPTY;
    if (m < 40) return SCORE_TOP;
    if (m < 45) return SCORE_EMPTY + 1;
    return $urandom;
  endfunction

  function automatic int pick_len();
    int m;
    m = $urandom_range(0, 99);
    if (m < 25) return 63;
    if (m < 37) return 0;
    return $urandom_range(0, 63);
  endfunction

  function automatic int pick_gap(input bit idle_on);
    if (!idle_on || n_sent >= planned - TAIL_ITEMS) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, 13);
    return 0;
  endfunction

  // writes mostly land around the window of the current focus cell, queries on or beside it
  function automatic command_t gen_command(input int fr, input int fc);
    command_t c;
    int m, lq, hq, lt, ht, span_q, span_t;
    lq = int'(win_lq);
    hq = int'(win_hq);
    lt = int'(win_lt);
    ht = int'(win_ht);
    span_q = (hq - lq < 0) ? 0 : ((hq - lq > 8) ? 8 : hq - lq);
    span_t = (ht - lt < 0) ? 0 : ((ht - lt > 8) ? 8 : ht - lt);
    c.typed = 1'b0;
    c.want.found = 1'b0;
    c.want.row = '0;
    c.want.col = '0;
    c.want.score = SCORE_EMPTY;
    c.row = 6'($urandom);
    c.col = 6'($urandom);
    c.score = $urandom;
    m = $urandom_range(0, 99);
    if (m < 2) begin
      c.kind = KIND_CLEAR;
    end else if (m < 4) begin
      c.kind = KIND_SPARE;
    end else if (m < 14) begin
      c.kind = ($urandom_range(0, 1) != 0) ? KIND_WRITE : KIND_QUERY;
    end else if (m < 55) begin
      c.kind = KIND_WRITE;
      c.row = 6'(clip63(fr + lq + int'($urandom_range(0, span_q + 2)) - 1));
      c.col = 6'(clip63(fc + lt + int'($urandom_range(0, span_t + 2)) - 1));
      c.score = pick_score();
    end else begin
      c.kind = KIND_QUERY;
      c.row = 6'(clip63(fr + int'($urandom_range(0, 2)) - 1));
      c.col = 6'(clip63(fc + int'($urandom_range(0, 2)) - 1));
    end
    return c;
  endfunction

  task automatic send_item(input command_t c, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind <= c.kind;
    row_index <= c.row;
    col_index <= c.col;
    score_in <= c.score;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_command(c);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_best.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_SRC_QL: src_ql = val[5:0];
      REG_SRC_TL: src_tl = val[5:0];
      REG_DST_QL: dst_ql = val[5:0];
      REG_DST_TL: dst_tl = val[5:0];
      REG_WIN_LQ: win_lq = val[8:0];
      REG_WIN_HQ: win_hq = val[8:0];
      REG_WIN_LT: win_lt = val[8:0];
      REG_WIN_HT: win_ht = val[8:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(input int sql, input int stl, input int dql, input int dtl,
                               input int lq, input int hq, input int lt, input int ht);
    apb_write(REG_SRC_QL, 32'(sql));
    apb_write(REG_SRC_TL, 32'(stl));
    apb_write(REG_DST_QL, 32'(dql));
    apb_write(REG_DST_TL, 32'(dtl));
    apb_write(REG_WIN_LQ, 32'(lq));
    apb_write(REG_WIN_HQ, 32'(hq));
    apb_write(REG_WIN_LT, 32'(lt));
    apb_write(REG_WIN_HT, 32'(ht));
    n_settings++;
  endtask

  task automatic pick_window(output int lo, output int hi);
    case ($urandom_range(0, 3))
      0: begin
        lo = int'($urandom_range(0, 4)) - 3;
        hi = lo + int'($urandom_range(0, 4));
      end
      1: begin
        lo = int'($urandom_range(0, 511)) - 256;
        hi = lo + int'($urandom_range(0, 5));
      end
      2: begin
        // reversed bounds: mostly an empty window
        lo = int'($urandom_range(0, 511)) - 256;
        hi = lo - int'($urandom_range(1, 3));
      end
      default: begin
        lo = -int'($urandom_range(0, 6));
        hi = lo + int'($urandom_range(0, 6));
      end
    endcase
    if (hi > 255) hi = 255;
    if (hi < -256) hi = -256;
  endtask

  always @(posedge clk) begin
    best_cell_t w;
    if (!rst && done) begin
      if (pending_best.size() == 0) begin
        $error("result with no query outstanding: found=%0d row=%0d col=%0d score=%0d",
               found, best_row, best_col, best_score);
        err_count++;
      end else begin
        w = pending_best.pop_front();
        if (found !== w.found) begin
          $error("found: expected %0d, got %0d", w.found, found);
          err_count++;
        end
        if (best_row !== w.row) begin
          $error("best_row: expected %0d, got %0d", w.row, best_row);
          err_count++;
        end
        if (best_col !== w.col) begin
          $error("best_col: expected %0d, got %0d", w.col, best_col);
          err_count++;
        end
        if (best_score !== w.score) begin
          $error("best_score: expected %0d, got %0d", w.score, best_score);
          err_count++;
        end
        if (found === 1'b1) n_hits++;
      end
    end
  end

  initial begin
    int p, k, fr, fc, lq, hq, lt, ht, phase_items;
    bit idle_on;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    start <= 1'b0;
    kind <= KIND_CLEAR;
    row_index <= '0;
    col_index <= '0;
    score_in <= '0;
    wipe_scores();
    src_ql = 6'd63;
    src_tl = 6'd63;
    dst_ql = 6'd63;
    dst_tl = 6'd63;
    win_lq = '0;
    win_hq = '0;
    win_lt = '0;
    win_ht = '0;
    fr = 0;
    fc = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    drain();  // reset sweep

    // reset windows are a single cell, so each query looks at its own cell
    add_row(KIND_QUERY, 0, 0, 0, 1, 1'b0, 0, 0, SCORE_EMPTY);
    add_row(KIND_QUERY, 63, 63, 0, 1, 1'b0, 0, 0, SCORE_EMPTY);
    add_row(KIND_WRITE, 63, 63, SCORE_TOP, 0, 1'b0, 0, 0, 0);
    add_row(KIND_QUERY, 63, 63, 0, 1, 1'b1, 63, 63, SCORE_TOP);
    add_row(KIND_WRITE, 0, 0, SCORE_EMPTY + 1, 0, 1'b0, 0, 0, 0);
    add_row(KIND_QUERY, 0, 0, 0, 1, 1'b1, 0, 0, SCORE_EMPTY + 1);
    add_row(KIND_WRITE, 0, 63, SCORE_EMPTY, 0, 1'b0, 0, 0, 0);
    add_row(KIND_QUERY, 0, 63, 0, 1, 1'b0, 0, 0, SCORE_EMPTY);
    add_row(KIND_WRITE, 63, 0, 0, 0, 1'b0, 0, 0, 0);
    add_row(KIND_QUERY, 63, 0, 0, 1, 1'b1, 63, 0, 0);
    add_row(KIND_WRITE, 21, 42, -1, 0, 1'b0, 0, 0, 0);
    add_row(KIND_QUERY, 21, 42, 0, 1, 1'b1, 21, 42, -1);
    add_row(KIND_SPARE, 63, 63, 5, 0, 1'b0, 0, 0, 0);
    add_row(KIND_QUERY, 63, 63, 0, 1, 1'b1, 63, 63, SCORE_TOP);
    add_row(KIND_WRITE, 42, 21, 32'sh5555_5555, 0, 1'b0, 0, 0, 0);
    add_row(KIND_QUERY, 42, 21, 0, 0, 1'b0, 0, 0, 0);
    add_row(KIND_WRITE, 10, 10, 32'shaaaa_aaaa, 0, 1'b0, 0, 0, 0);
    add_row(KIND_WRITE, 10, 10, 32'sh1234_5678, 0, 1'b0, 0, 0, 0);
    add_row(KIND_QUERY, 10, 10, 0, 0, 1'b0, 0, 0, 0);
    add_row(KIND_QUERY, 10, 11, 0, 0, 1'b0, 0, 0, 0);
    add_row(KIND_CLEAR, 0, 0, 0, 0, 1'b0, 0, 0, 0);
    add_row(KIND_QUERY, 63, 63, 0, 1, 1'b0, 0, 0, SCORE_EMPTY);
    add_row(KIND_QUERY, 0, 0, 0, 1, 1'b0, 0, 0, SCORE_EMPTY);

    planned = sweep_table.size() + 60 + 10 + 40 + 60 + (NUM_PHASES - 4) * 100;
    foreach (sweep_table[i]) send_item(sweep_table[i], pick_gap(1'b1));

    for (p = 0; p < NUM_PHASES; p++) begin
      drain();
      case (p)
        0: begin
          // one-cell source and destination, widest offsets
          load_settings(0, 0, 0, 0, -256, 255, -256, 255);
          phase_items = 60;
        end
        1: begin
          // every query scans the whole matrix: keep this short
          load_settings(63, 63, 63, 63, -256, 255, -256, 255);
          phase_items = 10;
        end
        2: begin
          load_settings(63, 63, 63, 63, 255, -256, 255, -256);
          phase_items = 40;
        end
        3: begin
          load_settings(63, 63, 63, 63, 0, 0, 0, 0);
          phase_items = 60;
        end
        default: begin
          pick_window(lq, hq);
          pick_window(lt, ht);
          load_settings(pick_len(), pick_len(), pick_len(), pick_len(), lq, hq, lt, ht);
          phase_items = 100;
        end
      endcase
      idle_on = (p % 3) != 2;
      for (k = 0; k < phase_items; k++) begin
        if (k == 0 || $urandom_range(0, 9) == 0) begin
          // one past the destination length reaches the out-of-range case
          fr = $urandom_range(0, int'(dst_ql) + 1);
          fc = $urandom_range(0, int'(dst_tl) + 1);
        end
        if (p >= 4 && $urandom_range(0, 99) == 0) drain();
        send_item(gen_command(fr, fc), pick_gap(idle_on));
      end
    end

    drain();
    repeat (16) @(posedge clk);
    $display("Sent %0d transfers: %0d writes, %0d queries (%0d found), %0d clears.",
             n_sent, n_writes, n_queries, n_hits, n_clears);
    $display("Loaded %0d register settings: extreme, reversed, empty and random windows.",
             n_settings);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* window_argmax_span_integrator.f */
hdl/wasi_pkg.sv
hdl/wasi_ram.sv
hdl/window_argmax_span_integrator.sv
hdl/wasi_checker.sv
bench/tb_window_argmax_span_integrator.sv
